// ===== hw/rtl/icbe_pkg.sv =====
package icbe_pkg;

    // Field widths fixed by the item and register formats.
    localparam int TIME_W    = 16;
    localparam int STRETCH_W = 20;
    localparam int ADDR_W    = 7;
    localparam int BYTE_W    = 8;
    localparam int CMD_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int BITCNT_W  = 4;
    localparam int CFG_IDX_W = 2;

    // Packed widths of the stream payloads.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 16;

    // Default sizing handed down from the top level.
    localparam int TIMER_BITS_DEF      = 16;
    localparam int RECOVERY_PULSES_DEF = 9;

    // Register reset values.
    localparam logic [TIME_W-1:0]    LOW_TIME_RST        = 16'd471;
    localparam logic [TIME_W-1:0]    HIGH_TIME_RST       = 16'd401;
    localparam logic                 STRETCH_ENABLE_RST  = 1'b0;
    localparam logic [STRETCH_W-1:0] STRETCH_TIMEOUT_RST = 20'd100000;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LOW_TIME        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIME       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH_ENABLE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRETCH_TIMEOUT = 2'd3;

    // Item kinds.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RECOVER = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NACK    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_TIMEOUT = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_HELD    = 2'd3;

    typedef struct packed {
        logic                 operation;
        logic [CMD_W-1:0]     command;
        logic [ADDR_W-1:0]    target_address;
        logic                 read_not_write;
        logic [BYTE_W-1:0]    write_data;
        logic                 last_read;
        logic                 sda_in;
        logic                 scl_in;
    } item_t;

    typedef struct packed {
        logic                 scl_out;
        logic                 sda_out;
        logic                 busy_res;
        logic                 done_res;
        logic [BYTE_W-1:0]    read_data;
        logic [STATUS_W-1:0]  status;
    } result_t;

    typedef struct packed {
        logic [TIME_W-1:0]    low_time;
        logic [TIME_W-1:0]    high_time;
        logic                 stretch_enable;
        logic [STRETCH_W-1:0] stretch_timeout;
    } cfg_t;

endpackage

// ===== hw/rtl/icbe_cfg_regs.sv =====
module icbe_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [icbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [icbe_pkg::STRETCH_W-1:0]  cfg_data,
    output icbe_pkg::cfg_t                  cfg
);

    icbe_pkg::cfg_t cfg_reg;
    icbe_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                icbe_pkg::REG_LOW_TIME:
                    cfg_next.low_time = cfg_data[icbe_pkg::TIME_W-1:0];
                icbe_pkg::REG_HIGH_TIME:
                    cfg_next.high_time = cfg_data[icbe_pkg::TIME_W-1:0];
                icbe_pkg::REG_STRETCH_ENABLE:
                    cfg_next.stretch_enable = cfg_data[0];
                icbe_pkg::REG_STRETCH_TIMEOUT:
                    cfg_next.stretch_timeout = cfg_data;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_time        <= icbe_pkg::LOW_TIME_RST;
            cfg_reg.high_time       <= icbe_pkg::HIGH_TIME_RST;
            cfg_reg.stretch_enable  <= icbe_pkg::STRETCH_ENABLE_RST;
            cfg_reg.stretch_timeout <= icbe_pkg::STRETCH_TIMEOUT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/icbe_pipe_reg.sv =====
module icbe_pipe_reg #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    // A request may enter while the held one leaves in the same cycle.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
            data_next  = in_data;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

endmodule

// ===== hw/rtl/icbe_bit_fsm.sv =====
module icbe_bit_fsm #(
    parameter int TIMER_BITS      = icbe_pkg::TIMER_BITS_DEF,
    parameter int RECOVERY_PULSES = icbe_pkg::RECOVERY_PULSES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  icbe_pkg::cfg_t    cfg,
    input  logic              item_valid,
    output logic              item_ready,
    input  icbe_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output icbe_pkg::result_t result
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_CHK, PH_START_PULSE, PH_START_SDA, PH_START_SCL,
        PH_RS_HIGH, PH_RS_SETUP, PH_WB_BIT, PH_WB_LOW, PH_ACK_HIGH, PH_ACK_SAMPLE,
        PH_RB_BIT, PH_RB_SAMPLE, PH_RB_ACK, PH_RB_ACKLOW, PH_SP_SDA, PH_SP_SCL,
        PH_SP_SETUP, PH_SP_REL, PH_REC_PULSE, PH_REC_LOW, PH_REC_CHECK, PH_FINISH
    } phase_t;

    phase_t                               phase_reg, phase_next;
    logic [TIMER_BITS-1:0]                phase_timer_reg, phase_timer_next;
    logic [icbe_pkg::BITCNT_W-1:0]        bit_count_reg, bit_count_next;
    logic [icbe_pkg::BYTE_W-1:0]          shift_reg, shift_next;
    logic [icbe_pkg::STRETCH_W-1:0]       stretch_timer_reg, stretch_timer_next;
    logic                                 stretch_wait_reg, stretch_wait_next;
    logic                                 scl_drive_reg, scl_drive_next;
    logic                                 sda_drive_reg, sda_drive_next;
    logic                                 in_tx_reg, in_tx_next;
    logic [icbe_pkg::CMD_W-1:0]           pending_cmd_reg, pending_cmd_next;
    logic                                 ack_mode_reg, ack_mode_next;
    logic [icbe_pkg::STATUS_W-1:0]        last_status_reg, last_status_next;
    logic [icbe_pkg::STATUS_W-1:0]        run_status_reg, run_status_next;
    logic [icbe_pkg::BYTE_W-1:0]          read_byte_reg, read_byte_next;

    logic                                 consume;
    logic                                 done;
    logic                                 go;
    logic [TIMER_BITS-1:0]                low_ticks;
    logic [TIMER_BITS-1:0]                high_ticks;
    logic [TIMER_BITS-1:0]                timer_dec;
    logic [icbe_pkg::STRETCH_W-1:0]       stretch_inc;
    logic [icbe_pkg::BITCNT_W-1:0]        bit_count_inc;

    // Phase delays saturate at the timer's full scale.
    if (TIMER_BITS >= icbe_pkg::TIME_W) begin : g_wide_timer
        assign low_ticks  = TIMER_BITS'(cfg.low_time);
        assign high_ticks = TIMER_BITS'(cfg.high_time);
    end else begin : g_narrow_timer
        assign low_ticks  = (|cfg.low_time[icbe_pkg::TIME_W-1:TIMER_BITS]) ?
                            '1 : cfg.low_time[TIMER_BITS-1:0];
        assign high_ticks = (|cfg.high_time[icbe_pkg::TIME_W-1:TIMER_BITS]) ?
                            '1 : cfg.high_time[TIMER_BITS-1:0];
    end

    assign consume       = item_valid && result_ready;
    assign item_ready    = result_ready;
    assign result_valid  = item_valid;
    assign timer_dec     = phase_timer_reg - TIMER_BITS'(1);
    assign stretch_inc   = (&stretch_timer_reg) ? stretch_timer_reg :
                           stretch_timer_reg + icbe_pkg::STRETCH_W'(1);
    assign bit_count_inc = bit_count_reg + icbe_pkg::BITCNT_W'(1);

    always_comb begin
        phase_next         = phase_reg;
        phase_timer_next   = phase_timer_reg;
        bit_count_next     = bit_count_reg;
        shift_next         = shift_reg;
        stretch_timer_next = stretch_timer_reg;
        stretch_wait_next  = stretch_wait_reg;
        scl_drive_next     = scl_drive_reg;
        sda_drive_next     = sda_drive_reg;
        in_tx_next         = in_tx_reg;
        pending_cmd_next   = pending_cmd_reg;
        ack_mode_next      = ack_mode_reg;
        last_status_next   = last_status_reg;
        run_status_next    = run_status_reg;
        read_byte_next     = read_byte_reg;
        done               = 1'b0;
        go                 = 1'b0;

        if (consume && item.operation == icbe_pkg::OP_COMMAND) begin
            // Commands are dropped while busy or when the code is unknown.
            if (phase_reg == PH_IDLE && item.command <= icbe_pkg::CMD_RECOVER) begin
                pending_cmd_next   = item.command;
                phase_timer_next   = '0;
                stretch_wait_next  = 1'b0;
                stretch_timer_next = '0;
                bit_count_next     = '0;
                run_status_next    = icbe_pkg::STAT_OK;
                shift_next         = '0;
                unique case (item.command)
                    icbe_pkg::CMD_START: begin
                        shift_next = {item.target_address, item.read_not_write};
                        phase_next = in_tx_reg ? PH_RS_HIGH : PH_START_CHK;
                    end
                    icbe_pkg::CMD_WRITE: begin
                        shift_next = item.write_data;
                        phase_next = PH_WB_BIT;
                    end
                    icbe_pkg::CMD_READ: begin
                        ack_mode_next = item.last_read;
                        phase_next    = PH_RB_BIT;
                    end
                    icbe_pkg::CMD_STOP: phase_next = PH_SP_SDA;
                    default:            phase_next = PH_START_CHK;
                endcase
            end
        end else if (consume && phase_reg != PH_IDLE) begin
            go = 1'b1;
            if (stretch_wait_reg) begin
                if (item.scl_in) begin
                    stretch_wait_next = 1'b0;
                end else begin
                    go                 = 1'b0;
                    stretch_timer_next = stretch_inc;
                    if (stretch_inc >= cfg.stretch_timeout) begin
                        scl_drive_next    = 1'b1;
                        sda_drive_next    = 1'b1;
                        in_tx_next        = 1'b0;
                        stretch_wait_next = 1'b0;
                        last_status_next  = icbe_pkg::STAT_TIMEOUT;
                        phase_next        = PH_IDLE;
                        phase_timer_next  = '0;
                        done              = 1'b1;
                    end
                end
            end
            if (go && phase_timer_reg != '0) begin
                phase_timer_next = timer_dec;
                if (timer_dec != '0) begin
                    go = 1'b0;
                end
            end
            if (go) begin
                unique case (phase_reg)
                    PH_START_CHK: begin
                        in_tx_next = 1'b1;
                        if (item.sda_in) begin
                            // SDA already high: pull it low right away.
                            sda_drive_next   = 1'b0;
                            phase_timer_next = high_ticks;
                            phase_next       = PH_START_SCL;
                        end else begin
                            scl_drive_next   = 1'b0;
                            phase_timer_next = low_ticks;
                            phase_next       = PH_START_PULSE;
                        end
                    end
                    PH_START_PULSE: begin
                        scl_drive_next     = 1'b1;
                        stretch_timer_next = '0;
                        stretch_wait_next  = cfg.stretch_enable;
                        phase_timer_next   = low_ticks;
                        phase_next         = PH_START_SDA;
                    end
                    PH_START_SDA: begin
                        sda_drive_next   = 1'b0;
                        phase_timer_next = high_ticks;
                        phase_next       = PH_START_SCL;
                    end
                    PH_START_SCL: begin
                        scl_drive_next   = 1'b0;
                        phase_timer_next = low_ticks;
                        if (pending_cmd_reg == icbe_pkg::CMD_RECOVER) begin
                            phase_next = (bit_count_reg == '0) ? PH_REC_PULSE : PH_SP_SDA;
                        end else begin
                            phase_next = PH_WB_BIT;
                        end
                    end
                    PH_RS_HIGH: begin
                        sda_drive_next     = 1'b1;
                        scl_drive_next     = 1'b1;
                        stretch_timer_next = '0;
                        stretch_wait_next  = cfg.stretch_enable;
                        phase_timer_next   = high_ticks;
                        phase_next         = PH_RS_SETUP;
                    end
                    PH_RS_SETUP: begin
                        phase_timer_next = low_ticks;
                        phase_next       = PH_START_CHK;
                    end
                    PH_WB_BIT: begin
                        sda_drive_next     = shift_reg[icbe_pkg::BYTE_W-1];
                        scl_drive_next     = 1'b1;
                        stretch_timer_next = '0;
                        stretch_wait_next  = cfg.stretch_enable;
                        phase_timer_next   = high_ticks;
                        phase_next         = PH_WB_LOW;
                    end
                    PH_WB_LOW: begin
                        scl_drive_next   = 1'b0;
                        shift_next       = {shift_reg[icbe_pkg::BYTE_W-2:0], 1'b0};
                        bit_count_next   = bit_count_inc;
                        phase_timer_next = low_ticks;
                        phase_next       = (bit_count_inc < icbe_pkg::BITCNT_W'(icbe_pkg::BYTE_W)) ?
                                           PH_WB_BIT : PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH, PH_RB_BIT, PH_REC_PULSE: begin
                        sda_drive_next     = 1'b1;
                        scl_drive_next     = 1'b1;
                        stretch_timer_next = '0;
                        stretch_wait_next  = cfg.stretch_enable;
                        phase_timer_next   = high_ticks;
                        if (phase_reg == PH_ACK_HIGH) begin
                            phase_next = PH_ACK_SAMPLE;
                        end else if (phase_reg == PH_RB_BIT) begin
                            phase_next = PH_RB_SAMPLE;
                        end else begin
                            phase_next = PH_REC_LOW;
                        end
                    end
                    PH_ACK_SAMPLE: begin
                        if (item.sda_in) begin
                            run_status_next = icbe_pkg::STAT_NACK;
                        end
                        scl_drive_next   = 1'b0;
                        phase_timer_next = low_ticks;
                        phase_next       = PH_FINISH;
                    end
                    PH_RB_SAMPLE: begin
                        shift_next       = {shift_reg[icbe_pkg::BYTE_W-2:0], item.sda_in};
                        scl_drive_next   = 1'b0;
                        bit_count_next   = bit_count_inc;
                        phase_timer_next = low_ticks;
                        phase_next       = (bit_count_inc < icbe_pkg::BITCNT_W'(icbe_pkg::BYTE_W)) ?
                                           PH_RB_BIT : PH_RB_ACK;
                    end
                    PH_RB_ACK: begin
                        sda_drive_next     = ack_mode_reg;
                        scl_drive_next     = 1'b1;
                        stretch_timer_next = '0;
                        stretch_wait_next  = cfg.stretch_enable;
                        phase_timer_next   = high_ticks;
                        phase_next         = PH_RB_ACKLOW;
                    end
                    PH_RB_ACKLOW: begin
                        scl_drive_next   = 1'b0;
                        read_byte_next   = shift_reg;
                        phase_timer_next = low_ticks;
                        phase_next       = PH_FINISH;
                    end
                    PH_SP_SDA: begin
                        sda_drive_next   = 1'b0;
                        phase_timer_next = low_ticks;
                        phase_next       = PH_SP_SCL;
                    end
                    PH_SP_SCL: begin
                        scl_drive_next     = 1'b1;
                        stretch_timer_next = '0;
                        stretch_wait_next  = cfg.stretch_enable;
                        phase_timer_next   = high_ticks;
                        phase_next         = PH_SP_SETUP;
                    end
                    PH_SP_SETUP: begin
                        phase_timer_next = high_ticks;
                        phase_next       = PH_SP_REL;
                    end
                    PH_SP_REL: begin
                        sda_drive_next   = 1'b1;
                        in_tx_next       = 1'b0;
                        phase_timer_next = low_ticks;
                        phase_next       = (pending_cmd_reg == icbe_pkg::CMD_RECOVER) ?
                                           PH_REC_CHECK : PH_FINISH;
                    end
                    PH_REC_LOW: begin
                        scl_drive_next   = 1'b0;
                        bit_count_next   = bit_count_inc;
                        phase_timer_next = low_ticks;
                        phase_next       = (bit_count_inc <
                                            icbe_pkg::BITCNT_W'(RECOVERY_PULSES)) ?
                                           PH_REC_PULSE : PH_RS_HIGH;
                    end
                    PH_REC_CHECK: begin
                        // The check finishes the command in the same tick.
                        run_status_next  = item.sda_in ? icbe_pkg::STAT_OK : icbe_pkg::STAT_HELD;
                        last_status_next = run_status_next;
                        phase_next       = PH_IDLE;
                        done             = 1'b1;
                    end
                    PH_FINISH: begin
                        last_status_next = run_status_reg;
                        phase_next       = PH_IDLE;
                        done             = 1'b1;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        result.scl_out   = scl_drive_next;
        result.sda_out   = sda_drive_next;
        result.busy_res  = (phase_next != PH_IDLE);
        result.done_res  = done;
        result.read_data = read_byte_next;
        result.status    = last_status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            phase_timer_reg   <= '0;
            bit_count_reg     <= '0;
            shift_reg         <= '0;
            stretch_timer_reg <= '0;
            stretch_wait_reg  <= 1'b0;
            scl_drive_reg     <= 1'b1;
            sda_drive_reg     <= 1'b1;
            in_tx_reg         <= 1'b0;
            pending_cmd_reg   <= icbe_pkg::CMD_START;
            ack_mode_reg      <= 1'b0;
            last_status_reg   <= icbe_pkg::STAT_OK;
            run_status_reg    <= icbe_pkg::STAT_OK;
            read_byte_reg     <= '0;
        end else begin
            phase_reg         <= phase_next;
            phase_timer_reg   <= phase_timer_next;
            bit_count_reg     <= bit_count_next;
            shift_reg         <= shift_next;
            stretch_timer_reg <= stretch_timer_next;
            stretch_wait_reg  <= stretch_wait_next;
            scl_drive_reg     <= scl_drive_next;
            sda_drive_reg     <= sda_drive_next;
            in_tx_reg         <= in_tx_next;
            pending_cmd_reg   <= pending_cmd_next;
            ack_mode_reg      <= ack_mode_next;
            last_status_reg   <= last_status_next;
            run_status_reg    <= run_status_next;
            read_byte_reg     <= read_byte_next;
        end
    end

endmodule

// ===== hw/rtl/i2c_controller_bit_engine.sv =====
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    tick or command request
// m_        out        m_tvalid/m_tready    line drives and status, one per request
// cfg_      in         cfg_valid/cfg_ready  register index and write data
//
// Every request produces exactly one result: the request is held in the input
// register, the state update works on it ahead of the result register, and
// the result leaves from there. A new request is accepted every cycle while
// m_tready is high. aresetn is synchronous and active low; it releases both
// lines and clears the engine. When m_tready is low the result register holds
// and at most one more request is taken into the input register.
module i2c_controller_bit_engine #(
    parameter int TIMER_BITS      = icbe_pkg::TIMER_BITS_DEF,
    parameter int RECOVERY_PULSES = icbe_pkg::RECOVERY_PULSES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command[2:0], target_address[9:3], read_not_write[10], write_data[18:11],
    // last_read[19], sda_in[20], scl_in[21], zero fill[23:22]
    input  logic [icbe_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation[0]
    input  logic [icbe_pkg::S_TUSER_W-1:0]  s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4],
    // status[13:12], zero fill[15:14]
    output logic [icbe_pkg::M_TDATA_W-1:0]  m_tdata,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [icbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [icbe_pkg::STRETCH_W-1:0]  cfg_data
);

    icbe_pkg::cfg_t    cfg;
    icbe_pkg::item_t   s_item;
    icbe_pkg::item_t   item;
    icbe_pkg::result_t result;
    icbe_pkg::result_t m_result;
    logic              item_valid;
    logic              item_ready;
    logic              result_valid;
    logic              result_ready;

    always_comb begin
        s_item.operation      = s_tuser[0];
        s_item.command        = s_tdata[2:0];
        s_item.target_address = s_tdata[9:3];
        s_item.read_not_write = s_tdata[10];
        s_item.write_data     = s_tdata[18:11];
        s_item.last_read      = s_tdata[19];
        s_item.sda_in         = s_tdata[20];
        s_item.scl_in         = s_tdata[21];
    end

    assign m_tdata = {2'b00, m_result.status, m_result.read_data, m_result.done_res,
                      m_result.busy_res, m_result.sda_out, m_result.scl_out};

    icbe_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    icbe_pipe_reg #(
        .WIDTH ($bits(icbe_pkg::item_t))
    ) u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_item),
        .out_valid (item_valid),
        .out_ready (item_ready),
        .out_data  (item)
    );

    icbe_bit_fsm #(
        .TIMER_BITS      (TIMER_BITS),
        .RECOVERY_PULSES (RECOVERY_PULSES)
    ) u_bit_fsm (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    icbe_pipe_reg #(
        .WIDTH ($bits(icbe_pkg::result_t))
    ) u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (result_valid),
        .in_ready  (result_ready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_result)
    );

endmodule

// ===== hw/rtl/icbe_checker.sv =====
module icbe_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [icbe_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic [icbe_pkg::S_TUSER_W-1:0]  s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [icbe_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                            cfg_valid,
    input logic                            cfg_ready,
    input logic [icbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [icbe_pkg::STRETCH_W-1:0]  cfg_data
);

    // Reset empties both pipeline stages; only the result stage is checked here.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // With the result side open, the input side must never stall.
    a_full_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while results drain");

    // A finishing command leaves the engine idle.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
        else $error("done reported while still busy");

    // A stalled result holds its value.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind i2c_controller_bit_engine icbe_checker u_checker (.*);

// ===== dv/i2c_line_checker.sv =====
module i2c_line_checker (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // command[2:0], target_address[9:3], read_not_write[10], write_data[18:11],
    // last_read[19], sda_in[20], scl_in[21], zero fill[23:22]
    input  logic [icbe_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation[0]
    input  logic [icbe_pkg::S_TUSER_W-1:0]  s_tuser,

    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4],
    // status[13:12], zero fill[15:14]
    input  logic [icbe_pkg::M_TDATA_W-1:0]  m_tdata,

    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [icbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [icbe_pkg::STRETCH_W-1:0]  cfg_data,

    output int                              fail_count,
    output int                              pending_n
);
    import icbe_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_START_CHK, PH_START_PULSE, PH_START_SDA, PH_START_SCL,
        PH_RS_HIGH, PH_RS_SETUP, PH_WB_BIT, PH_WB_LOW, PH_ACK_HIGH, PH_ACK_SAMPLE,
        PH_RB_BIT, PH_RB_SAMPLE, PH_RB_ACK, PH_RB_ACKLOW, PH_SP_SDA, PH_SP_SCL,
        PH_SP_SETUP, PH_SP_REL, PH_REC_PULSE, PH_REC_LOW, PH_REC_CHECK, PH_FINISH
    } bus_phase_e;

    // Register copies.
    logic [TIME_W-1:0]    low_t;
    logic [TIME_W-1:0]    high_t;
    logic                 stretch_en;
    logic [STRETCH_W-1:0] stretch_tmo;

    // Engine state as the bus sequencer sees it.
    bus_phase_e           phase;
    logic [TIME_W-1:0]    phase_timer;
    logic [BITCNT_W-1:0]  bit_cnt;
    logic [BYTE_W-1:0]    shifter;
    logic [STRETCH_W-1:0] stretch_cnt;
    logic                 stretch_wait;
    logic                 scl_drv;
    logic                 sda_drv;
    logic                 in_xfer;
    logic [CMD_W-1:0]     cur_cmd;
    logic                 ack_bit;
    logic [STATUS_W-1:0]  status_q;
    logic [STATUS_W-1:0]  run_stat;
    logic [BYTE_W-1:0]    rx_byte;

    result_t              expected_lines [$];
    result_t              exp_line;
    result_t              got_line;

    function automatic void clear_engine();
        low_t        = LOW_TIME_RST;
        high_t       = HIGH_TIME_RST;
        stretch_en   = STRETCH_ENABLE_RST;
        stretch_tmo  = STRETCH_TIMEOUT_RST;
        phase        = PH_IDLE;
        phase_timer  = '0;
        bit_cnt      = '0;
        shifter      = '0;
        stretch_cnt  = '0;
        stretch_wait = 1'b0;
        scl_drv      = 1'b1;
        sda_drv      = 1'b1;
        in_xfer      = 1'b0;
        cur_cmd      = CMD_START;
        ack_bit      = 1'b0;
        status_q     = STAT_OK;
        run_stat     = STAT_OK;
        rx_byte      = '0;
    endfunction

    function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [STRETCH_W-1:0] val);
        case (idx)
            REG_LOW_TIME:        low_t = val[TIME_W-1:0];
            REG_HIGH_TIME:       high_t = val[TIME_W-1:0];
            REG_STRETCH_ENABLE:  stretch_en = val[0];
            REG_STRETCH_TIMEOUT: stretch_tmo = val;
            default: ;
        endcase
    endfunction

    // The delay registers are as wide as the phase timer, so no saturation is needed.
    function automatic void load_wait(logic [TIME_W-1:0] ticks, bus_phase_e nxt);
        phase_timer = ticks;
        phase = nxt;
    endfunction

    function automatic void release_scl();
        scl_drv = 1'b1;
        stretch_cnt = '0;
        stretch_wait = stretch_en;
    endfunction

    // Runs line actions until one of them has to wait; returns 1 when a command ends.
    function automatic logic advance_bus(logic sda);
        logic finished;
        logic again;
        finished = 1'b0;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (phase)
                PH_START_CHK: begin
                    in_xfer = 1'b1;
                    if (sda) begin
                        phase = PH_START_SDA;
                        again = 1'b1;
                    end else begin
                        // SDA is held low, so give the target one clock first.
                        scl_drv = 1'b0;
                        load_wait(low_t, PH_START_PULSE);
                    end
                end
                PH_START_PULSE: begin
                    release_scl();
                    load_wait(low_t, PH_START_SDA);
                end
                PH_START_SDA: begin
                    sda_drv = 1'b0;
                    load_wait(high_t, PH_START_SCL);
                end
                PH_START_SCL: begin
                    scl_drv = 1'b0;
                    if (cur_cmd == CMD_RECOVER) begin
                        load_wait(low_t, (bit_cnt == 0) ? PH_REC_PULSE : PH_SP_SDA);
                    end else begin
                        load_wait(low_t, PH_WB_BIT);
                    end
                end
                PH_RS_HIGH: begin
                    sda_drv = 1'b1;
                    release_scl();
                    load_wait(high_t, PH_RS_SETUP);
                end
                PH_RS_SETUP: load_wait(low_t, PH_START_CHK);
                PH_WB_BIT: begin
                    sda_drv = shifter[BYTE_W-1];
                    release_scl();
                    load_wait(high_t, PH_WB_LOW);
                end
                PH_WB_LOW: begin
                    scl_drv = 1'b0;
                    shifter = shifter << 1;
                    bit_cnt = bit_cnt + 1'b1;
                    load_wait(low_t, (bit_cnt < BYTE_W) ? PH_WB_BIT : PH_ACK_HIGH);
                end
                PH_ACK_HIGH: begin
                    sda_drv = 1'b1;
                    release_scl();
                    load_wait(high_t, PH_ACK_SAMPLE);
                end
                PH_RB_BIT: begin
                    sda_drv = 1'b1;
                    release_scl();
                    load_wait(high_t, PH_RB_SAMPLE);
                end
                PH_REC_PULSE: begin
                    sda_drv = 1'b1;
                    release_scl();
                    load_wait(high_t, PH_REC_LOW);
                end
                PH_ACK_SAMPLE: begin
                    if (sda) run_stat = STAT_NACK;
                    scl_drv = 1'b0;
                    load_wait(low_t, PH_FINISH);
                end
                PH_RB_SAMPLE: begin
                    shifter = {shifter[BYTE_W-2:0], sda};
                    scl_drv = 1'b0;
                    bit_cnt = bit_cnt + 1'b1;
                    load_wait(low_t, (bit_cnt < BYTE_W) ? PH_RB_BIT : PH_RB_ACK);
                end
                PH_RB_ACK: begin
                    sda_drv = ack_bit;
                    release_scl();
                    load_wait(high_t, PH_RB_ACKLOW);
                end
                PH_RB_ACKLOW: begin
                    scl_drv = 1'b0;
                    rx_byte = shifter;
                    load_wait(low_t, PH_FINISH);
                end
                PH_SP_SDA: begin
                    sda_drv = 1'b0;
                    load_wait(low_t, PH_SP_SCL);
                end
                PH_SP_SCL: begin
                    release_scl();
                    load_wait(high_t, PH_SP_SETUP);
                end
                PH_SP_SETUP: load_wait(high_t, PH_SP_REL);
                PH_SP_REL: begin
                    sda_drv = 1'b1;
                    in_xfer = 1'b0;
                    load_wait(low_t, (cur_cmd == CMD_RECOVER) ? PH_REC_CHECK : PH_FINISH);
                end
                PH_REC_LOW: begin
                    scl_drv = 1'b0;
                    bit_cnt = bit_cnt + 1'b1;
                    load_wait(low_t, (bit_cnt < RECOVERY_PULSES_DEF) ? PH_REC_PULSE
                                                                      : PH_RS_HIGH);
                end
                PH_REC_CHECK: begin
                    run_stat = sda ? STAT_OK : STAT_HELD;
                    phase = PH_FINISH;
                    again = 1'b1;
                end
                PH_FINISH: begin
                    status_q = run_stat;
                    phase = PH_IDLE;
                    finished = 1'b1;
                end
                default: phase = PH_IDLE;
            endcase
        end
        return finished;
    endfunction

    // Applies one request to the engine and returns the line state it leaves.
    function automatic result_t apply_request(logic op, logic [S_TDATA_W-1:0] data);
        logic [CMD_W-1:0] cmd;
        logic             sda;
        logic             scl;
        logic             go;
        logic             done;
        result_t          r;
        cmd  = data[2:0];
        sda  = data[20];
        scl  = data[21];
        go   = 1'b1;
        done = 1'b0;
        if (op == OP_COMMAND) begin
            // Commands arriving mid-command or with an unused code are dropped.
            if (phase == PH_IDLE && cmd <= CMD_RECOVER) begin
                cur_cmd      = cmd;
                phase_timer  = '0;
                stretch_wait = 1'b0;
                stretch_cnt  = '0;
                bit_cnt      = '0;
                run_stat     = STAT_OK;
                shifter      = '0;
                case (cmd)
                    CMD_START: begin
                        shifter = {data[9:3], data[10]};
                        phase = in_xfer ? PH_RS_HIGH : PH_START_CHK;
                    end
                    CMD_WRITE: begin
                        shifter = data[18:11];
                        phase = PH_WB_BIT;
                    end
                    CMD_READ: begin
                        ack_bit = data[19];
                        phase = PH_RB_BIT;
                    end
                    CMD_STOP: phase = PH_SP_SDA;
                    default:  phase = PH_START_CHK;
                endcase
            end
        end else if (phase != PH_IDLE) begin
            if (stretch_wait) begin
                if (scl) begin
                    stretch_wait = 1'b0;
                end else begin
                    if (stretch_cnt != '1) stretch_cnt = stretch_cnt + 1'b1;
                    if (stretch_cnt >= stretch_tmo) begin
                        // The target held SCL too long: let go of the bus entirely.
                        scl_drv      = 1'b1;
                        sda_drv      = 1'b1;
                        in_xfer      = 1'b0;
                        stretch_wait = 1'b0;
                        status_q     = STAT_TIMEOUT;
                        phase        = PH_IDLE;
                        phase_timer  = '0;
                        done         = 1'b1;
                    end
                    go = 1'b0;
                end
            end
            if (go && phase_timer != 0) begin
                phase_timer = phase_timer - 1'b1;
                if (phase_timer != 0) go = 1'b0;
            end
            if (go) done = advance_bus(sda);
        end
        r.scl_out   = scl_drv;
        r.sda_out   = sda_drv;
        r.busy_res  = (phase != PH_IDLE);
        r.done_res  = done;
        r.read_data = rx_byte;
        r.status    = status_q;
        return r;
    endfunction

    initial begin
        fail_count = 0;
        pending_n = 0;
        clear_engine();
    end

    // Results are compared before new requests are queued so that a result can
    // never be matched against an expectation created at the same edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_engine();
            expected_lines.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_line.scl_out   = m_tdata[0];
                got_line.sda_out   = m_tdata[1];
                got_line.busy_res  = m_tdata[2];
                got_line.done_res  = m_tdata[3];
                got_line.read_data = m_tdata[11:4];
                got_line.status    = m_tdata[13:12];
                if (expected_lines.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("checker: result %h arrived with nothing expected", m_tdata);
                    end
                    fail_count++;
                end else begin
                    exp_line = expected_lines.pop_front();
                    if (got_line.scl_out !== exp_line.scl_out
                            || got_line.sda_out !== exp_line.sda_out
                            || got_line.busy_res !== exp_line.busy_res
                            || got_line.done_res !== exp_line.done_res
                            || got_line.read_data !== exp_line.read_data
                            || got_line.status !== exp_line.status) begin
                        if (fail_count < 10) begin
                            $display("checker: mismatch at %0t", $realtime);
                            $display("  expected scl=%b sda=%b busy=%b done=%b rd=%h st=%0d",
                                     exp_line.scl_out, exp_line.sda_out, exp_line.busy_res,
                                     exp_line.done_res, exp_line.read_data, exp_line.status);
                            $display("  actual   scl=%b sda=%b busy=%b done=%b rd=%h st=%0d",
                                     got_line.scl_out, got_line.sda_out, got_line.busy_res,
                                     got_line.done_res, got_line.read_data, got_line.status);
                        end
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
            if (s_tvalid && s_tready) begin
                expected_lines.push_back(apply_request(s_tuser[0], s_tdata));
            end
        end
        pending_n = expected_lines.size();
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import icbe_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int M_BUSY_BIT    = 2;
    localparam int M_DONE_BIT    = 3;
    localparam int M_STATUS_LSB  = 12;
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [STRETCH_W-1:0]   cfg_data  = '0;

    int  fail_count;
    int  pending_n;

    int  sent_n      = 0;
    int  got_n       = 0;
    int  done_n      = 0;
    int  cycle_n     = 0;
    int  cfg_sets    = 0;
    int  outcome_n [4] = '{0, 0, 0, 0};
    logic last_busy  = 1'b0;

    // Stimulus shaping.
    int  sda_hi_pct  = 50;
    int  scl_lo_pct  = 10;
    bit  no_idle     = 1'b0;
    int  hold_n      = 0;
    int  stall_len;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    i2c_controller_bit_engine DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    i2c_line_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending_n  (pending_n)
    );

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_request(
            logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr, logic rnw,
            logic [BYTE_W-1:0] wdata, logic last, logic sda, logic scl);
        return {2'b00, scl, sda, last, wdata, rnw, addr, cmd};
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return '0;
        if (r < 85) return TIME_W'($urandom_range(1, 4));
        return TIME_W'($urandom_range(5, 12));
    endfunction

    // Result receiver: random back-pressure, mostly short stalls.
    always @(negedge aclk) begin
        if (hold_n > 0) begin
            m_tready <= 1'b0;
            hold_n = hold_n - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_len = pick_gap();
            m_tready <= (stall_len == 0);
            hold_n = (stall_len > 0) ? stall_len - 1 : 0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_n <= cycle_n + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got_n <= got_n + 1;
            last_busy <= m_tdata[M_BUSY_BIT];
            if (m_tdata[M_DONE_BIT]) begin
                done_n <= done_n + 1;
                outcome_n[m_tdata[M_STATUS_LSB +: STATUS_W]] <=
                    outcome_n[m_tdata[M_STATUS_LSB +: STATUS_W]] + 1;
            end
        end
        if (cycle_n >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles without finishing.", cycle_n);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Leaves s_tvalid high on return; callers either send the next request in
    // the same step or lower it before waiting.
    task automatic push_item(input logic op, input logic [S_TDATA_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        sent_n++;
    endtask

    task automatic push_tick();
        push_item(OP_TICK, pack_request(CMD_W'($urandom), ADDR_W'($urandom),
                                        1'($urandom), BYTE_W'($urandom), 1'($urandom),
                                        chance(sda_hi_pct), !chance(scl_lo_pct)));
    endtask

    // Sends a command and, for a known code, clocks the engine until it reports completion.
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                         input logic rnw, input logic [BYTE_W-1:0] wdata,
                         input logic last);
        int done_before;
        done_before = done_n;
        push_item(OP_COMMAND, pack_request(cmd, addr, rnw, wdata, last,
                                           1'($urandom), 1'($urandom)));
        if (cmd > CMD_RECOVER) return;
        // A second request right behind a live command must be dropped.
        if ($urandom_range(0, 6) == 0) begin
            push_item(OP_COMMAND, pack_request(CMD_W'($urandom), ADDR_W'($urandom),
                                               1'($urandom), BYTE_W'($urandom),
                                               1'($urandom), 1'($urandom), 1'($urandom)));
        end
        while (done_n == done_before) push_tick();
    endtask

    // Holds off new commands until every result is back and the engine is idle, sending ticks while it is busy.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (got_n != sent_n || last_busy) begin
            if (got_n == sent_n) begin
                push_tick();
                s_tvalid <= 1'b0;
            end
            @(negedge aclk);
        end
    endtask

    task automatic load_config(input cfg_t c);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [STRETCH_W-1:0] val [4];
        idx[0] = REG_LOW_TIME;        val[0] = STRETCH_W'(c.low_time);
        idx[1] = REG_HIGH_TIME;       val[1] = STRETCH_W'(c.high_time);
        idx[2] = REG_STRETCH_ENABLE;  val[2] = STRETCH_W'(c.stretch_enable);
        idx[3] = REG_STRETCH_TIMEOUT; val[3] = c.stretch_timeout;
        settle();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        cfg_sets++;
    endtask

    function automatic cfg_t timing(logic [TIME_W-1:0] lo, logic [TIME_W-1:0] hi,
                                    logic en, logic [STRETCH_W-1:0] tmo);
        cfg_t c;
        c.low_time = lo;
        c.high_time = hi;
        c.stretch_enable = en;
        c.stretch_timeout = tmo;
        return c;
    endfunction

    task automatic random_transaction();
        int               r;
        int               n_bytes;
        logic             rnw;
        logic [ADDR_W-1:0] addr;
        r       = $urandom_range(0, 99);
        n_bytes = $urandom_range(1, 3);
        rnw     = 1'($urandom);
        addr    = ADDR_W'($urandom);
        if (r < 8) begin
            issue(CMD_RECOVER, addr, rnw, BYTE_W'($urandom), 1'($urandom));
        end else if (r < 14) begin
            // Lone commands outside any transaction, or codes the engine ignores.
            case ($urandom_range(0, 3))
                0: issue(CMD_WRITE, addr, rnw, BYTE_W'($urandom), 1'($urandom));
                1: issue(CMD_READ, addr, rnw, BYTE_W'($urandom), 1'($urandom));
                2: issue(CMD_STOP, addr, rnw, BYTE_W'($urandom), 1'($urandom));
                default: issue(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                               addr, rnw, BYTE_W'($urandom), 1'($urandom));
            endcase
        end else begin
            issue(CMD_START, addr, rnw, BYTE_W'($urandom), 1'($urandom));
            for (int i = 0; i < n_bytes; i++) begin
                if (rnw) issue(CMD_READ, addr, rnw, BYTE_W'($urandom), i == n_bytes - 1);
                else     issue(CMD_WRITE, addr, rnw, BYTE_W'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 3) == 0) begin
                issue(CMD_START, addr, !rnw, BYTE_W'($urandom), 1'($urandom));
                if (!rnw) issue(CMD_READ, addr, 1'b1, BYTE_W'($urandom), 1'b1);
                else      issue(CMD_WRITE, addr, 1'b0, BYTE_W'($urandom), 1'($urandom));
            end
            if ($urandom_range(0, 9) != 0) issue(CMD_STOP, addr, rnw, BYTE_W'($urandom), 1'b0);
        end
    endtask

    initial begin
        int random_floor;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset defaults: idle ticks and unused command codes only.
        repeat (4) push_tick();
        for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++) begin
            issue(CMD_W'(c), ADDR_W'($urandom), 1'($urandom), BYTE_W'($urandom), 1'($urandom));
        end

        load_config(timing(16'd1, 16'd1, 1'b0, 20'd100000));
        sda_hi_pct = 0;
        issue(CMD_START, 7'h7F, 1'b1, 8'h00, 1'b0);
        sda_hi_pct = 100;
        issue(CMD_WRITE, 7'h00, 1'b0, 8'hFF, 1'b0);
        sda_hi_pct = 0;
        issue(CMD_WRITE, 7'h00, 1'b0, 8'h00, 1'b1);
        sda_hi_pct = 50;
        issue(CMD_READ, 7'h00, 1'b0, 8'h5A, 1'b0);
        issue(CMD_READ, 7'h00, 1'b0, 8'hA5, 1'b1);
        issue(CMD_START, 7'h00, 1'b0, 8'h00, 1'b0);
        issue(CMD_STOP, 7'h55, 1'b1, 8'h00, 1'b0);
        issue(CMD_WRITE, 7'h2A, 1'b0, 8'hA5, 1'b0);
        issue(CMD_READ, 7'h2A, 1'b1, 8'h00, 1'b1);
        issue(CMD_STOP, 7'h2A, 1'b0, 8'h00, 1'b0);
        sda_hi_pct = 100;
        issue(CMD_RECOVER, 7'h00, 1'b0, 8'h00, 1'b0);
        sda_hi_pct = 0;
        issue(CMD_RECOVER, 7'h00, 1'b0, 8'h00, 1'b0);

        // Zero delays and a zero stretch timeout: the first low SCL aborts.
        load_config(timing(16'd0, 16'd0, 1'b1, 20'd0));
        sda_hi_pct = 50;
        scl_lo_pct = 100;
        issue(CMD_WRITE, 7'h00, 1'b0, 8'hC3, 1'b0);
        scl_lo_pct = 0;
        issue(CMD_START, 7'h33, 1'b0, 8'h00, 1'b0);
        issue(CMD_STOP, 7'h33, 1'b0, 8'h00, 1'b0);

        // Full-scale phase times, cut short by the smallest nonzero stretch timeout.
        load_config(timing(16'hFFFF, 16'hFFFF, 1'b1, 20'd1));
        scl_lo_pct = 100;
        issue(CMD_WRITE, 7'h00, 1'b0, 8'h81, 1'b0);

        load_config(timing(16'd2, 16'd3, 1'b1, 20'hFFFFF));
        scl_lo_pct = 30;
        issue(CMD_START, 7'h4C, 1'b1, 8'h00, 1'b0);
        issue(CMD_READ, 7'h4C, 1'b1, 8'h00, 1'b1);
        issue(CMD_STOP, 7'h4C, 1'b1, 8'h00, 1'b0);

        random_floor = sent_n + RANDOM_ITEMS;
        while (sent_n < random_floor) begin
            load_config(timing(pick_time(), pick_time(), 1'($urandom),
                               chance(40) ? STRETCH_W'($urandom_range(0, 6)) :
                               chance(50) ? STRETCH_W'($urandom_range(7, 40)) :
                                            STRETCH_W'($urandom)));
            sda_hi_pct = $urandom_range(20, 95);
            scl_lo_pct = $urandom_range(0, 40);
            no_idle = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 5)) random_transaction();
        end

        settle();
        repeat (6) @(negedge aclk);
        $display("Covered %0d requests over %0d register settings; %0d commands finished.",
                 sent_n, cfg_sets, done_n);
        $display("Outcomes: ok %0d, nack %0d, stretch timeout %0d, bus held %0d.",
                 outcome_n[STAT_OK], outcome_n[STAT_NACK], outcome_n[STAT_TIMEOUT],
                 outcome_n[STAT_HELD]);
        if (fail_count == 0 && pending_n == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/icbe_pkg.sv
hw/rtl/icbe_cfg_regs.sv
hw/rtl/icbe_pipe_reg.sv
hw/rtl/icbe_bit_fsm.sv
hw/rtl/i2c_controller_bit_engine.sv
hw/rtl/icbe_checker.sv
dv/i2c_line_checker.sv
dv/tb_top.sv
